// ----- sv/tlbs_pkg.sv -----
package tlbs_pkg;

    localparam int IN_DATA_BITS  = 32;
    localparam int IN_USER_BITS  = 3;
    localparam int FIELD_BITS    = 11;
    localparam int RES_BITS      = 35;
    localparam int OUT_DATA_BITS = 40;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_BINARY = 2'd2;

    localparam logic [FIELD_BITS-1:0] POS_NONE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

endpackage

// ----- sv/tlbs_table.sv -----
module tlbs_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  logic [VALUE_BITS-1:0]          wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output logic [VALUE_BITS-1:0]          rd_data
);

    logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tlbs_cmp.sv -----
module tlbs_cmp #(
    parameter int VALUE_BITS = 32
) (
    input  logic signed [VALUE_BITS-1:0] target,
    input  logic signed [VALUE_BITS-1:0] entry,
    output tlbs_pkg::cmp_t               result
);

    import tlbs_pkg::*;

    // gt means the target lies above the table entry
    always_comb
    begin
        result.eq = (target == entry);
        result.gt = (target > entry);
    end

endmodule

// ----- sv/table_linear_binary_search.sv -----
// channel  dir  handshake            payload
// s        in   s_tvalid / s_tready  s_tdata value, s_tuser mode and restart
// m        out  m_tvalid / m_tready  m_tdata found, position, attempts, full, count
//
// one table probe per cycle through the single memory read port and comparator
// append or unused mode: no probe; S_IDLE goes to S_DONE, which loads the output register once it is free
// linear search: k probes, k up to the entry count
// binary search: each probe halves the range between first and last
// reset clears the entry count, the state and the output valid; the table is not swept
// a result waits in the output register; a new request is taken meanwhile
module table_linear_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // value[31:0]
    input  logic [tlbs_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // mode[1:0], restart[2]
    input  logic [tlbs_pkg::IN_USER_BITS-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found[0], position[11:1], attempts[22:12], table_full[23],
    // entry_count[34:24], zero[39:35]
    output logic [tlbs_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    import tlbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] probe_reg, probe_next;
    logic [CW-1:0] tries_reg, tries_next;
    logic [VALUE_BITS-1:0] target_reg, target_next;
    logic linear_reg, linear_next;
    logic [RES_BITS-1:0] res_reg, res_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic signed [63:0] value_ext;
    logic [VALUE_BITS-1:0] value_in;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [VALUE_BITS-1:0] rd_data;
    cmp_t cmp;

    logic [CW-1:0] n;
    logic [CW-1:0] tries_inc;
    logic [AW-1:0] nf;
    logic [AW-1:0] nl;
    logic [AW-1:0] mid;

    assign value_ext = 64'(signed'(s_tdata));
    assign value_in  = value_ext[VALUE_BITS-1:0];

    tlbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tlbs_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .target (target_reg),
        .entry  (rd_data),
        .result (cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        last_reg    <= last_next;
        probe_reg   <= probe_next;
        tries_reg   <= tries_next;
        target_reg  <= target_next;
        linear_reg  <= linear_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        probe_next    = probe_reg;
        tries_next    = tries_reg;
        target_next   = target_reg;
        linear_next   = linear_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_addr       = probe_reg;
        n             = s_tuser[2] ? '0 : count_reg;
        tries_inc     = tries_reg + CW'(1);
        nf            = probe_reg + AW'(1);
        nl            = probe_reg - AW'(1);
        mid           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    target_next = value_in;
                    tries_next  = '0;
                    first_next  = '0;
                    last_next   = AW'(count_reg - CW'(1));
                    state_next  = S_DONE;
                    case (s_tuser[1:0])
                        MODE_APPEND:
                        begin
                            if (n == CW'(TABLE_DEPTH))
                            begin
                                count_next = n;
                                res_next = {FIELD_BITS'(n), 1'b1, FIELD_BITS'(0),
                                            POS_NONE, 1'b0};
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = n[AW-1:0];
                                count_next = n + CW'(1);
                                res_next = {FIELD_BITS'(n + CW'(1)), 1'b0,
                                            FIELD_BITS'(0), FIELD_BITS'(n), 1'b0};
                            end
                        end
                        MODE_LINEAR, MODE_BINARY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = {FIELD_BITS'(count_reg), 1'b0,
                                            FIELD_BITS'(0), POS_NONE, 1'b0};
                            end
                            else
                            begin
                                linear_next = (s_tuser[1:0] == MODE_LINEAR);
                                if (s_tuser[1:0] == MODE_LINEAR)
                                begin
                                    mid = '0;
                                end
                                else
                                begin
                                    mid = AW'(count_reg - CW'(1)) >> 1;
                                end
                                probe_next = mid;
                                rd_addr    = mid;
                                state_next = S_PROBE;
                            end
                        end
                        default:
                        begin
                            res_next = {FIELD_BITS'(count_reg), 1'b0,
                                        FIELD_BITS'(0), POS_NONE, 1'b0};
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                // default is a miss; overridden on a hit
                res_next = {FIELD_BITS'(count_reg), 1'b0, FIELD_BITS'(tries_inc),
                            POS_NONE, 1'b0};
                if (cmp.eq)
                begin
                    res_next = {FIELD_BITS'(count_reg), 1'b0, FIELD_BITS'(tries_inc),
                                FIELD_BITS'(probe_reg), 1'b1};
                    state_next = S_DONE;
                end
                else if (linear_reg)
                begin
                    if ((CW'(probe_reg) + CW'(1)) < count_reg)
                    begin
                        probe_next = nf;
                        rd_addr    = nf;
                        tries_next = tries_inc;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (cmp.gt)
                begin
                    // search the upper half, first = mid + 1
                    if (probe_reg < last_reg)
                    begin
                        mid        = nf + ((last_reg - nf) >> 1);
                        first_next = nf;
                        probe_next = mid;
                        rd_addr    = mid;
                        tries_next = tries_inc;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // search the lower half, last = mid - 1
                    if (probe_reg > first_reg)
                    begin
                        mid        = first_reg + ((nl - first_reg) >> 1);
                        last_next  = nl;
                        probe_next = mid;
                        rd_addr    = mid;
                        tries_next = tries_inc;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_BITS'(res_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/tlbs_checker.sv -----
module tlbs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [tlbs_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input logic [tlbs_pkg::IN_USER_BITS-1:0]  s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tlbs_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    import tlbs_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a hit costs at least one comparison
    a_hit_tries: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[22:12] != 11'd0)
        else $error("hit reported with no comparisons");

    // a dropped append has no slot and no hit
    a_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23] |-> m_tdata[11:1] == POS_NONE && !m_tdata[0])
        else $error("dropped append shows a slot");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("padding bits set");

endmodule

bind table_linear_binary_search tlbs_checker u_tlbs_checker (.*);
